// ----- sv/byte_plane_rle_encoder_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte plane RLE encoder
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BYTE_PLANE_RLE_ENCODER_CORE_MACROS_SVH
`define BYTE_PLANE_RLE_ENCODER_CORE_MACROS_SVH

// Same-cycle implication.
`define BPRE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bpre_pkg.sv -----
// ---------------------------------------------------------------------------
// bpre_pkg
// Shared constants and types for the byte plane RLE encoder.
// ---------------------------------------------------------------------------
package bpre_pkg;

  localparam int MAX_PACKET_ITEMS_DEF = 128;
  localparam int BYTES_PER_WORD_DEF   = 8;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 8;   // packet item count, up to 128
  localparam int WORD_W   = 64;
  localparam int OCNT_W   = 4;
  localparam int LANES    = 8;
  localparam int LANE_W   = 3;
  localparam int OUT_TD_W = 72;  // 64 word + 4 count, padded to bytes

  localparam logic RUN_PKT = 1'b1;

  // one packet waiting to be sent
  typedef struct packed {
    logic              run;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] data;  // repeated byte of a run packet
  } pkt_t;

  // one byte beat into the word packer
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pkt_last;
    logic              item_last;
  } pk_byte_t;

endpackage

// ----- sv/bpre_store.sv -----
// ---------------------------------------------------------------------------
// bpre_store
// Literal byte buffer: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bpre_store #(
  parameter int DEPTH = bpre_pkg::MAX_PACKET_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bpre_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [bpre_pkg::BYTE_W-1:0] rd_data
);
  import bpre_pkg::*;

  logic [BYTE_W-1:0] store_mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/bpre_pack.sv -----
// ---------------------------------------------------------------------------
// bpre_pack
// Packs packet bytes into output words, first byte lowest; a packet end
// closes the word. Output register decouples the byte side from the bus.
// ---------------------------------------------------------------------------
module bpre_pack #(
  parameter int BYTES_PER_WORD = bpre_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  bpre_pkg::pk_byte_t            byte_in,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bpre_pkg::OUT_TD_W-1:0] out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);
  import bpre_pkg::*;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(BYTES_PER_WORD - 1);

  logic [WORD_W-1:0] acc_r,      acc_nxt;
  logic [LANE_W-1:0] lane_r,     lane_nxt;
  logic              ovalid_r,   ovalid_nxt;
  logic [WORD_W-1:0] oword_r,    oword_nxt;
  logic [OCNT_W-1:0] ocnt_r,     ocnt_nxt;
  logic              olast_r,    olast_nxt;
  logic              ouser_r,    ouser_nxt;
  logic [WORD_W-1:0] merged;
  logic              fire;
  logic              word_done;

  assign byte_ready = !ovalid_r || out_tready;
  assign fire       = byte_valid && byte_ready;
  assign word_done  = byte_in.pkt_last || (lane_r == LAST_LANE);

  always_comb begin
    merged = acc_r;
    for (int i = 0; i < LANES; i++) begin
      if (lane_r == LANE_W'(i)) begin
        merged[i*BYTE_W +: BYTE_W] = byte_in.data;
      end
    end
  end

  always_comb begin
    acc_nxt    = acc_r;
    lane_nxt   = lane_r;
    ovalid_nxt = ovalid_r && !out_tready;
    oword_nxt  = oword_r;
    ocnt_nxt   = ocnt_r;
    olast_nxt  = olast_r;
    ouser_nxt  = ouser_r;
    if (fire) begin
      if (word_done) begin
        oword_nxt  = merged;
        ocnt_nxt   = {1'b0, lane_r} + OCNT_W'(1);
        olast_nxt  = byte_in.pkt_last;
        ouser_nxt  = byte_in.item_last;
        ovalid_nxt = 1'b1;
        acc_nxt    = '0;
        lane_nxt   = '0;
      end else begin
        acc_nxt  = merged;
        lane_nxt = lane_r + LANE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      lane_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      lane_r   <= lane_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oword_r <= oword_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {(OUT_TD_W - WORD_W - OCNT_W)'(0), ocnt_r, oword_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

endmodule

// ----- sv/byte_plane_rle_encoder_core.sv -----
// ---------------------------------------------------------------------------
// byte_plane_rle_encoder_core
// Byte plane run-length encoder with TGA-style packets, packed into words.
// ---------------------------------------------------------------------------
// Takes one source byte per input beat (tlast marks the last byte of a plane)
// and emits packets of a control byte ({run, count-1}) and data, packed into
// 64-bit words of up to BYTES_PER_WORD bytes; tlast on a word marks packet
// end, tuser marks the last word caused by the input byte. An input beat
// that closes no packet is taken while idle; one that closes packets stalls
// input until each packet byte (control byte, then one byte for a run or
// count bytes for a literal) has left, as open literal bytes live in a
// single read-port buffer read back one byte per cycle while the packer
// takes bytes. No clearing pass after reset; the block accepts input right away.
module byte_plane_rle_encoder_core #(
  parameter int MAX_PACKET_ITEMS = bpre_pkg::MAX_PACKET_ITEMS_DEF,
  parameter int BYTES_PER_WORD   = bpre_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // plane_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bpre_pkg::OUT_TD_W-1:0] out_tdata,  // [63:0] out_word, [67:64] out_count
  output logic                          out_tlast,  // packet_end
  output logic                          out_tuser   // last_of_input
);
  import bpre_pkg::*;
  `include "byte_plane_rle_encoder_core_macros.svh"

  localparam int AW = $clog2(MAX_PACKET_ITEMS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_ITEMS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_r,     state_nxt;
  logic [CNT_W-1:0]  pending_r,   pending_nxt;
  logic              run_mode_r,  run_mode_nxt;
  logic              pair_r,      pair_nxt;
  logic [BYTE_W-1:0] prev_byte_r, prev_byte_nxt;
  logic              prev_vld_r,  prev_vld_nxt;
  pkt_t              cur_r,       cur_nxt;
  pkt_t              next_r,      next_nxt;
  logic              has_next_r,  has_next_nxt;
  logic [CNT_W-1:0]  idx_r,       idx_nxt;

  logic              in_fire;
  logic              match;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              rd_en;
  pkt_t              pkt_a, pkt_b;
  logic              a_vld, b_vld;
  logic [CNT_W-1:0]  lit_cnt;
  logic [CNT_W-1:0]  last_idx;
  logic              byte_valid, byte_ready, byte_fire;
  pk_byte_t          byte_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign match     = prev_vld_r && (in_tdata == prev_byte_r);
  assign lit_cnt   = pending_r + CNT_W'(1) - CNT_W'(3);

  // accept: update packet state, note up to two packets to send
  always_comb begin
    pending_nxt   = pending_r;
    run_mode_nxt  = run_mode_r;
    pair_nxt      = pair_r;
    prev_byte_nxt = prev_byte_r;
    prev_vld_nxt  = prev_vld_r;
    wr_en         = 1'b0;
    wr_addr       = pending_r[AW-1:0];
    a_vld         = 1'b0;
    pkt_a         = '{run: RUN_PKT, cnt: pending_r, data: prev_byte_r};
    b_vld         = 1'b0;
    pkt_b         = '{run: 1'b0, cnt: '0, data: in_tdata};
    if (in_fire) begin
      if (run_mode_r) begin
        if (match) begin
          pending_nxt = pending_r + CNT_W'(1);
        end else begin
          // run broken: send it, the new byte opens a literal
          a_vld        = 1'b1;
          wr_en        = 1'b1;
          wr_addr      = '0;
          pending_nxt  = CNT_W'(1);
          run_mode_nxt = 1'b0;
          pair_nxt     = 1'b0;
        end
      end else begin
        wr_en       = 1'b1;
        pending_nxt = pending_r + CNT_W'(1);
        if (match) begin
          if (pair_r) begin
            // third equal byte: close the literal before the pair
            a_vld        = (lit_cnt != '0);
            pkt_a        = '{run: 1'b0, cnt: lit_cnt, data: in_tdata};
            run_mode_nxt = 1'b1;
            pending_nxt  = CNT_W'(3);
            pair_nxt     = 1'b0;
          end else begin
            pair_nxt = 1'b1;
          end
        end else begin
          pair_nxt = 1'b0;
        end
      end
      prev_byte_nxt = in_tdata;
      prev_vld_nxt  = 1'b1;
      if (in_tlast || (pending_nxt >= MAX_CNT)) begin
        b_vld        = 1'b1;
        pkt_b        = '{run: run_mode_nxt, cnt: pending_nxt, data: in_tdata};
        pending_nxt  = '0;
        run_mode_nxt = 1'b0;
        pair_nxt     = 1'b0;
        prev_vld_nxt = 1'b0;
        if (in_tlast) begin
          prev_byte_nxt = '0;
        end
      end
    end
  end

  // byte sequencer over the current packet
  assign last_idx   = cur_r.run ? CNT_W'(1) : cur_r.cnt;
  assign byte_valid = (state_r == ST_EMIT);
  assign byte_fire  = byte_valid && byte_ready;
  // fetch the buffer byte for the next beat as this one leaves
  assign rd_en      = byte_fire;

  always_comb begin
    byte_out.pkt_last  = (idx_r == last_idx);
    byte_out.item_last = (idx_r == last_idx) && !has_next_r;
    if (idx_r == '0) begin
      byte_out.data = {cur_r.run, 7'(cur_r.cnt - CNT_W'(1))};
    end else if (cur_r.run) begin
      byte_out.data = cur_r.data;
    end else begin
      byte_out.data = rd_data;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    next_nxt     = next_r;
    has_next_nxt = has_next_r;
    idx_nxt      = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (a_vld) begin
          cur_nxt      = pkt_a;
          next_nxt     = pkt_b;
          has_next_nxt = b_vld;
          state_nxt    = ST_EMIT;
        end else if (b_vld) begin
          cur_nxt      = pkt_b;
          has_next_nxt = 1'b0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (byte_fire) begin
          if (byte_out.pkt_last) begin
            idx_nxt = '0;
            if (has_next_r) begin
              cur_nxt      = next_r;
              has_next_nxt = 1'b0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= '0;
      run_mode_r  <= 1'b0;
      pair_r      <= 1'b0;
      prev_byte_r <= '0;
      prev_vld_r  <= 1'b0;
      has_next_r  <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      run_mode_r  <= run_mode_nxt;
      pair_r      <= pair_nxt;
      prev_byte_r <= prev_byte_nxt;
      prev_vld_r  <= prev_vld_nxt;
      has_next_r  <= has_next_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    next_r <= next_nxt;
  end

  bpre_store #(
    .DEPTH (MAX_PACKET_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  bpre_pack #(
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_in    (byte_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `BPRE_ASSERT_IMPL(a_pend_below_max, 1'b1, pending_r < MAX_CNT, "open packet reached max size")
  `BPRE_ASSERT_IMPL(a_run_has_three, run_mode_r, (pending_r >= CNT_W'(3)) && prev_vld_r, "run packet too short")
  `BPRE_ASSERT_IMPL(a_pair_in_literal, pair_r, !run_mode_r, "pair flag set in run mode")
  `BPRE_ASSERT_IMPL(a_idx_in_packet, state_r == ST_EMIT, idx_r <= last_idx, "byte index past packet end")
  `BPRE_ASSERT_NEXT(a_emit_after_close, in_fire && (in_tlast || a_vld), state_r == ST_EMIT, "closed packet not sent")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks byte_plane_rle_encoder_core word by word against a local encoder.
// ---------------------------------------------------------------------------
// Source bytes go in as planes: a short hand-picked set first, then a long
// plane that fills a literal packet to the 128-item limit and follows it with
// the same byte, then random planes whose runs, pairs and literals come from
// a per-plane repeat rate. Each accepted beat runs through the local encoder,
// and the words it predicts are matched in order against the words the block
// sends. Both sides idle at random.
module tb;

  import bpre_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       plane_end;
  } src_beat_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        pkt_end;
    logic        last_in;
  } word_beat_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;
  logic                out_tlast;
  logic                out_tuser;

  src_beat_t  pending_bytes[$];
  word_beat_t expected_words[$];
  int unsigned mismatches = 0;

  // encoder state
  logic [7:0]  lit_buf [0:127];
  int unsigned open_count = 0;
  bit          open_is_run = 0;
  bit          saw_pair = 0;
  bit          prev_ok = 0;
  logic [7:0]  prev_byte = '0;

  byte_plane_rle_encoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [71:0] got, logic [71:0] want);
    if (mismatches < 100)
      $display("tb: mismatch at %0t on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Split one packet into words, control byte first.
  task automatic pack_packet(bit is_run, int unsigned cnt, logic [7:0] run_byte);
    logic [7:0]  pkt_bytes[$];
    word_beat_t  w;
    int unsigned pos;
    int unsigned n;
    if (cnt == 0) return;
    if (cnt > 128) cnt = 128;
    pkt_bytes.push_back({is_run, 7'(cnt - 1)});
    if (is_run) begin
      pkt_bytes.push_back(run_byte);
    end else begin
      for (int unsigned i = 0; i < cnt; i++) pkt_bytes.push_back(lit_buf[i]);
    end
    pos = 0;
    while (pos < pkt_bytes.size()) begin
      w.word = '0;
      n = 0;
      while (n < 8 && pos < pkt_bytes.size()) begin
        w.word[8*n +: 8] = pkt_bytes[pos];
        n++;
        pos++;
      end
      w.count   = 4'(n);
      w.pkt_end = (pos >= pkt_bytes.size());
      w.last_in = 1'b0;
      expected_words.push_back(w);
    end
  endtask

  task automatic encode_byte(logic [7:0] b, bit last);
    int unsigned words_before;
    bit          match;
    word_beat_t  w;
    words_before = expected_words.size();
    match  = prev_ok && (b == prev_byte);
    if (open_is_run) begin
      if (match) begin
        open_count++;
      end else begin
        pack_packet(1'b1, open_count, prev_byte);
        lit_buf[0]  = b;
        open_count  = 1;
        open_is_run = 0;
        saw_pair    = 0;
      end
    end else begin
      if (open_count < 128) lit_buf[open_count] = b;
      open_count++;
      if (match && saw_pair) begin
        // third equal byte: close the literal without the last three, start a run
        pack_packet(1'b0, (open_count >= 3) ? open_count - 3 : 0, 8'h00);
        open_is_run = 1;
        open_count  = 3;
        saw_pair    = 0;
      end else begin
        saw_pair = match;
      end
    end
    prev_byte = b;
    prev_ok   = 1;
    if (last || open_count >= 128) begin
      pack_packet(open_is_run, open_count, prev_byte);
      open_count  = 0;
      open_is_run = 0;
      saw_pair    = 0;
      prev_ok     = 0;
      if (last) prev_byte = '0;
    end
    if (expected_words.size() > words_before) begin
      w = expected_words.pop_back();
      w.last_in = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  // sender: bursts of random length, random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  src_beat_t   next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_beat = pending_bytes.pop_front();
          in_tdata  <= next_beat.data;
          in_tlast  <= next_beat.plane_end;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall behavior switches between a few modes
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_phase = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      stall_phase = (stall_phase + 1) % 16;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 2) == 0);
        default: out_tready <= (stall_phase >= 10);
      endcase
    end
  end

  word_beat_t got_beat;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, '0);
      end else begin
        got_beat = expected_words.pop_front();
        if (out_tdata[63:0] !== got_beat.word)
          report_mismatch("out_word", out_tdata[63:0], got_beat.word);
        if (out_tdata[67:64] !== got_beat.count)
          report_mismatch("out_count", out_tdata[67:64], got_beat.count);
        if (out_tdata[71:68] !== 4'h0)
          report_mismatch("tdata pad", out_tdata[71:68], 0);
        if (out_tlast !== got_beat.pkt_end)
          report_mismatch("packet_end", out_tlast, got_beat.pkt_end);
        if (out_tuser !== got_beat.last_in)
          report_mismatch("last_of_input", out_tuser, got_beat.last_in);
      end
    end
  end

  task automatic add_byte(logic [7:0] b, bit last);
    src_beat_t s;
    s.data      = b;
    s.plane_end = last;
    pending_bytes.push_back(s);
  endtask

  // repeat_pct sets how often a byte equals the one before it
  task automatic add_plane(int unsigned len, int unsigned repeat_pct);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) >= repeat_pct) b = b + 8'($urandom_range(1, 255));
      add_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int unsigned random_items;
    int unsigned len;
    int unsigned pct;

    // single-byte planes at both extremes
    add_byte(8'h00, 1);
    add_byte(8'hff, 1);
    // run right at plane start, no literal ahead of it
    add_byte(8'haa, 0); add_byte(8'haa, 0); add_byte(8'haa, 1);
    // literal of one, then a run of four
    add_byte(8'h12, 0); add_byte(8'h34, 0); add_byte(8'h34, 0);
    add_byte(8'h34, 0); add_byte(8'h34, 1);
    // pair only stays literal
    add_byte(8'h55, 0); add_byte(8'h55, 1);
    add_byte(8'h01, 0); add_byte(8'h02, 0); add_byte(8'h02, 0); add_byte(8'h03, 1);
    // run broken by a new byte
    add_byte(8'h7f, 0); add_byte(8'h7f, 0); add_byte(8'h7f, 0);
    add_byte(8'h80, 0); add_byte(8'h81, 1);
    // new plane starts with the byte the old one ended on
    add_byte(8'h80, 1);
    add_byte(8'h80, 0); add_byte(8'h80, 0); add_byte(8'h80, 1);

    // packet limit: 128 distinct literal bytes, then the last one three more
    // times; the first repeat must not match across the forced close
    for (int unsigned i = 0; i < 128; i++) add_byte(8'(i * 3), 0);
    add_byte(8'h7d, 0); add_byte(8'h7d, 0); add_byte(8'h7d, 1);

    random_items = 0;
    while (random_items < 24) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 30;
        2: pct = 60;
        default: pct = 90;
      endcase
      add_plane(len, pct);
      random_items += len;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_bytes.size() > 0 || in_tvalid);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/bpre_pkg.sv
sv/bpre_store.sv
sv/bpre_pack.sv
sv/byte_plane_rle_encoder_core.sv
tb/tb.sv
